>>> rtl/core/drc_pkg.sv
// Shared types and constants for the duplicate row counter.
// No dependencies; imported by every module of the block.
package drc_pkg;

   localparam int ROW_W    = 64;
   localparam int DIM_W    = 7;
   localparam int RIDX_W   = 6;
   localparam int OCC_W    = 7;
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PICK,
      ST_BASE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [RIDX_W-1:0] row_index;
      logic [OCC_W-1:0]  occurrences;
      logic              last_group;
   } result_type;

endpackage

>>> rtl/core/drc_row_mem.sv
// Row storage: one write port and one read port with registered read data.
// Depends on drc_pkg for the row width.
module drc_row_mem #(
   parameter int MAX_DIM = 64,
   parameter int IW      = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IW-1:0]             wr_addr,
   input  logic [drc_pkg::ROW_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [IW-1:0]             rd_addr,
   output logic [drc_pkg::ROW_W-1:0] rd_data
);
   import drc_pkg::*;

   logic [ROW_W-1:0] mem [MAX_DIM];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/drc_group_ctrl.sv
// Load counter, grouping sequencer and row comparator.
// Depends on drc_pkg; drives the ports of drc_row_mem.
module drc_group_ctrl #(
   parameter int MAX_DIM = 64,
   parameter int IW      = 6,
   parameter int NW      = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [NW-1:0]             dim,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [drc_pkg::ROW_W-1:0] req_row_bits,
   output logic                      wr_en,
   output logic [IW-1:0]             wr_addr,
   output logic [drc_pkg::ROW_W-1:0] wr_data,
   output logic                      rd_en,
   output logic [IW-1:0]             rd_addr,
   input  logic [drc_pkg::ROW_W-1:0] rd_data,
   output logic                      res_valid,
   input  logic                      res_ready,
   output drc_pkg::result_type       res
);
   import drc_pkg::*;

   state_type        state_ff, state_in;
   logic [IW-1:0]    load_cnt_ff, load_cnt_in;
   logic [IW-1:0]    i_ff, i_in;
   logic [IW-1:0]    j_ff, j_in;
   logic [NW-1:0]    occ_ff, occ_in;
   logic [ROW_W-1:0] base_ff, base_in;
   logic [MAX_DIM-1:0] seen_ff, seen_in;

   logic             accept;
   logic             load_done;
   logic [NW-1:0]    load_next;
   logic [NW-1:0]    i_next;
   logic [NW-1:0]    j_next;
   logic [ROW_W-1:0] col_mask;
   logic             row_match;
   logic             more_groups;

   assign accept    = req_valid && req_ready;
   assign load_next = {1'b0, load_cnt_ff} + NW'(1);
   assign load_done = load_next >= dim;
   assign i_next    = {1'b0, i_ff} + NW'(1);
   assign j_next    = {1'b0, j_ff} + NW'(1);

   always_comb begin
      for (int k = 0; k < ROW_W; k++) begin
         col_mask[k] = (k < int'(dim));
      end
   end

   assign row_match = ((base_ff ^ rd_data) & col_mask) == '0;

   // A later group exists if any row after i and inside the matrix is unclaimed.
   always_comb begin
      more_groups = 1'b0;
      for (int k = 0; k < MAX_DIM; k++) begin
         if (!seen_ff[k] && (k > int'(i_ff)) && (k < int'(dim))) begin
            more_groups = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && load_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (!seen_ff[i_ff]) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            state_in = (i_next < dim) ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            if (!(j_next < dim)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (res_ready) begin
               state_in = more_groups ? ST_PICK : ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = i_ff;
      res_valid = 1'b0;
      case (state_ff)
         ST_LOAD: req_ready = 1'b1;
         ST_PICK: begin
            rd_en   = !seen_ff[i_ff];
            rd_addr = i_ff;
         end
         ST_BASE: begin
            rd_en   = i_next < dim;
            rd_addr = i_next[IW-1:0];
         end
         ST_SCAN: begin
            rd_en   = j_next < dim;
            rd_addr = j_next[IW-1:0];
         end
         ST_EMIT: res_valid = 1'b1;
         default: ;
      endcase
   end

   assign wr_en   = accept;
   assign wr_addr = load_cnt_ff;
   assign wr_data = req_row_bits;

   assign res.row_index   = RIDX_W'(i_ff);
   assign res.occurrences = OCC_W'(occ_ff);
   assign res.last_group  = !more_groups;

   // Datapath registers.
   always_comb begin
      load_cnt_in = load_cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      occ_in      = occ_ff;
      base_in     = base_ff;
      seen_in     = seen_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               load_cnt_in = load_done ? '0 : load_next[IW-1:0];
               i_in        = '0;
               seen_in     = '0;
            end
         end
         ST_PICK: begin
            if (seen_ff[i_ff]) begin
               i_in = i_next[IW-1:0];
            end
         end
         ST_BASE: begin
            base_in = rd_data;
            occ_in  = NW'(1);
            j_in    = i_next[IW-1:0];
         end
         ST_SCAN: begin
            if (row_match) begin
               occ_in        = occ_ff + NW'(1);
               seen_in[j_ff] = 1'b1;
            end
            j_in = j_next[IW-1:0];
         end
         ST_EMIT: begin
            if (res_ready) begin
               if (more_groups) begin
                  i_in = i_next[IW-1:0];
               end else begin
                  seen_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         seen_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      occ_ff  <= occ_in;
      base_ff <= base_in;
   end

endmodule

>>> rtl/core/duplicate_row_counter.sv
// Duplicate row counter: rows load at one beat per cycle while the block is not
// grouping. The last row of a matrix starts grouping: each unclaimed row is read
// as a base, every later row is scanned, matches are counted and claimed, and one
// result per group leaves through a one-beat output register; claimed rows are
// skipped. Synchronous reset clears control state and sets dimension to 64; the
// row memory is not cleared.
module duplicate_row_counter #(
   parameter int MAX_DIM = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [drc_pkg::DIM_W-1:0]    csr_dimension,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [drc_pkg::ROW_W-1:0]    req_row_bits,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [drc_pkg::RIDX_W-1:0]   rsp_row_index,
   output logic [drc_pkg::OCC_W-1:0]    rsp_occurrences,
   output logic                         rsp_last_group
);
   import drc_pkg::*;

   localparam int IW = $clog2(MAX_DIM);
   localparam int NW = IW + 1;

   logic [DIM_W-1:0] dim_ff, dim_in;
   logic [NW-1:0]    eff_dim;
   logic             wr_en, rd_en;
   logic [IW-1:0]    wr_addr, rd_addr;
   logic [ROW_W-1:0] wr_data, rd_data;
   logic             res_valid, res_ready;
   result_type       res;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;

   assign csr_ready = 1'b1;
   assign dim_in    = (csr_valid && csr_ready) ? csr_dimension : dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else begin
         dim_ff <= dim_in;
      end
   end

   // Zero counts as one; anything above the memory depth saturates.
   always_comb begin
      if (dim_ff == '0) begin
         eff_dim = NW'(1);
      end else if (dim_ff > DIM_W'(MAX_DIM)) begin
         eff_dim = NW'(MAX_DIM);
      end else begin
         eff_dim = dim_ff[NW-1:0];
      end
   end

   drc_row_mem #(
      .MAX_DIM (MAX_DIM),
      .IW      (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   drc_group_ctrl #(
      .MAX_DIM (MAX_DIM),
      .IW      (IW),
      .NW      (NW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .dim          (eff_dim),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_row_bits (req_row_bits),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // The output register takes a new beat whenever it is empty or draining.
   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = res_ready ? res_valid : rsp_valid_ff;
   assign rsp_in       = (res_ready && res_valid) ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = rsp_ff.row_index;
   assign rsp_occurrences = rsp_ff.occurrences;
   assign rsp_last_group  = rsp_ff.last_group;

endmodule
